FILE: rtl/upd_pkg.sv
// Package for the URL percent decoder: character codes, widths, the burst
// record passed from the decoder stage to the result stage, and the hex helper.
// No dependencies.
package upd_pkg;

    // Width of the decoded-length counter.
    localparam int LenW = 16;
    localparam logic [LenW-1:0] LenMax = {LenW{1'b1}};

    // Reset value of the output capacity register.
    localparam logic [15:0] CapReset = 16'd64;

    // Character codes.
    localparam logic [7:0] ChrPlus  = 8'h2B;
    localparam logic [7:0] ChrPct   = 8'h25;
    localparam logic [7:0] ChrSpace = 8'h20;
    localparam logic [7:0] ChrNul   = 8'h00;

    // What the decoder is holding between characters.
    typedef enum logic [1:0] {
        PEND_NONE  = 2'd0,
        PEND_PCT   = 2'd1,
        PEND_DIGIT = 2'd2
    } t_pend;

    // Results caused by one input item: up to three characters, then an
    // optional terminator result after them.
    typedef struct packed {
        logic [2:0][7:0] chars;
        logic [1:0]      num_chars;
        logic            fin;
    } t_burst;

    // Hex digit value of a character; bit 4 is set when the character is a
    // hex digit of either case.
    function automatic logic [4:0] hex_nibble(input logic [7:0] c);
        logic [4:0] r;
        r = 5'd0;
        if (c >= 8'h30 && c <= 8'h39) begin
            r = {1'b1, 4'(c - 8'h30)};
        end else if (c >= 8'h61 && c <= 8'h66) begin
            r = {1'b1, 4'(c - 8'h57)};
        end else if (c >= 8'h41 && c <= 8'h46) begin
            r = {1'b1, 4'(c - 8'h37)};
        end
        return r;
    endfunction

endpackage

FILE: rtl/upd_decode.sv
// Input register and decode stage of the URL percent decoder.
// Holds the pending '%' / digit state and turns one item into a result burst.
// Depends on upd_pkg.
module upd_decode
    import upd_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_s_tvalid,
    output logic       o_s_tready,
    input  logic [7:0] i_s_tdata,
    input  logic       i_s_tlast,
    output t_burst     o_burst,
    output logic       o_burst_vld,
    input  logic       i_burst_take
);

    // Input register.
    logic       r_in_vld;
    logic [7:0] r_char;
    logic       r_eot;

    // Pending state.
    t_pend      r_pend, n_pend;
    logic [7:0] r_held, n_held;

    logic [4:0] hi;
    logic [4:0] lo;

    assign hi = hex_nibble(r_held);
    assign lo = hex_nibble(r_char);

    // The input register takes a new transfer when empty or when its item moves on.
    assign o_s_tready  = !r_in_vld || i_burst_take;
    assign o_burst_vld = r_in_vld;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
            r_pend   <= PEND_NONE;
            r_held   <= 8'h00;
        end else begin
            if (o_s_tready) begin
                r_in_vld <= i_s_tvalid;
            end
            if (i_burst_take) begin
                r_pend <= n_pend;
                r_held <= n_held;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_s_tvalid && o_s_tready) begin
            r_char <= i_s_tdata;
            r_eot  <= i_s_tlast;
        end
    end

    // Next pending state.
    always_comb begin
        logic fresh;
        fresh  = 1'b0;
        n_pend = r_pend;
        n_held = r_held;
        if (r_eot) begin
            n_pend = PEND_NONE;
            n_held = 8'h00;
        end else begin
            case (r_pend)
                PEND_PCT: begin
                    if (lo[4]) begin
                        n_held = r_char;
                        n_pend = PEND_DIGIT;
                    end else begin
                        n_pend = PEND_NONE;
                        fresh  = 1'b1;
                    end
                end
                PEND_DIGIT: begin
                    n_pend = PEND_NONE;
                    n_held = 8'h00;
                    fresh  = !(hi[4] && lo[4]);
                end
                default: begin
                    n_pend = PEND_NONE;
                    fresh  = 1'b1;
                end
            endcase
            // A fresh '%' starts a new escape.
            if (fresh && r_char == ChrPct) begin
                n_pend = PEND_PCT;
            end
        end
    end

    // Result burst for the item in the input register.
    always_comb begin
        logic       fresh;
        logic [1:0] pre;
        fresh             = 1'b0;
        pre               = 2'd0;
        o_burst.chars     = '0;
        o_burst.num_chars = 2'd0;
        o_burst.fin       = 1'b0;
        if (r_eot) begin
            // Flush whatever is held, then the terminator.
            o_burst.fin = 1'b1;
            case (r_pend)
                PEND_PCT: begin
                    o_burst.chars[0]  = ChrPct;
                    o_burst.num_chars = 2'd1;
                end
                PEND_DIGIT: begin
                    o_burst.chars[0]  = ChrPct;
                    o_burst.chars[1]  = r_held;
                    o_burst.num_chars = 2'd2;
                end
                default: begin
                    o_burst.num_chars = 2'd0;
                end
            endcase
        end else begin
            case (r_pend)
                PEND_PCT: begin
                    if (!lo[4]) begin
                        o_burst.chars[0] = ChrPct;
                        pre              = 2'd1;
                        fresh            = 1'b1;
                    end
                end
                PEND_DIGIT: begin
                    if (hi[4] && lo[4]) begin
                        o_burst.chars[0]  = {hi[3:0], lo[3:0]};
                        o_burst.num_chars = 2'd1;
                    end else begin
                        o_burst.chars[0] = ChrPct;
                        o_burst.chars[1] = r_held;
                        pre              = 2'd2;
                        fresh            = 1'b1;
                    end
                end
                default: begin
                    fresh = 1'b1;
                end
            endcase
            // Plain decode of the current character behind any flushed ones.
            if (fresh) begin
                o_burst.num_chars = pre;
                if (r_char == ChrPlus) begin
                    o_burst.chars[pre] = ChrSpace;
                    o_burst.num_chars  = pre + 2'd1;
                end else if (r_char != ChrPct) begin
                    o_burst.chars[pre] = r_char;
                    o_burst.num_chars  = pre + 2'd1;
                end
            end
        end
    end

    // A held digit is always a hex digit.
    a_held_hex: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend == PEND_DIGIT |-> hi[4])
        else $error("held digit is not a hex digit");

    // An end marker leaves nothing pending.
    a_eot_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_burst_take && r_eot) |=> (r_pend == PEND_NONE && r_held == 8'h00))
        else $error("pending state survived an end marker");

    // Only a stored item can move to the result stage.
    a_take_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_burst_take |-> r_in_vld)
        else $error("burst taken from an empty input register");

endmodule

FILE: rtl/upd_emit.sv
// Result stage of the URL percent decoder: burst register, length counter,
// capacity register and the master-side stream outputs.
// Depends on upd_pkg.
module upd_emit
    import upd_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_burst      i_burst,
    input  logic        i_burst_vld,
    output logic        o_burst_take,
    input  logic        i_cfg_we,
    input  logic [15:0] i_cfg_wdata,
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [23:0] o_m_tdata,
    output logic        o_m_tuser,
    output logic        o_m_tlast
);

    logic [2:0][7:0] r_chars;
    logic [1:0]      r_left;
    logic            r_fin;
    logic [LenW-1:0] r_count, n_count;
    logic [15:0]     r_cap;

    logic            xfer;
    logic            cur_final;
    logic [32:0]     pos1;
    logic [31:0]     shown;
    logic [15:0]     total;

    assign o_m_tvalid   = (r_left != 2'd0);
    assign xfer         = o_m_tvalid && i_m_tready;
    assign cur_final    = r_fin && (r_left == 2'd1);
    assign o_burst_take = i_burst_vld && ((r_left == 2'd0) || (r_left == 2'd1 && i_m_tready));

    // Length after the current result; the terminator reports without counting.
    always_comb begin
        if (cur_final) begin
            n_count = r_count;
        end else if (r_count != LenMax) begin
            n_count = r_count + 1'b1;
        end else begin
            n_count = r_count;
        end
    end

    assign pos1  = 33'(r_count) + 33'd1;
    assign shown = 32'(n_count);
    assign total = (shown > 32'h0000_FFFF) ? 16'hFFFF : shown[15:0];

    // Result fields.
    assign o_m_tlast = cur_final;
    assign o_m_tuser = cur_final ? (r_cap != 16'd0) : (pos1 < 33'(r_cap));
    assign o_m_tdata = {total, (cur_final ? ChrNul : r_chars[0])};

    // Control registers and counter.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left  <= 2'd0;
            r_fin   <= 1'b0;
            r_count <= '0;
            r_cap   <= CapReset;
        end else begin
            if (i_cfg_we) begin
                r_cap <= i_cfg_wdata;
            end
            if (o_burst_take) begin
                r_left <= i_burst.num_chars + {1'b0, i_burst.fin};
                r_fin  <= i_burst.fin;
            end else if (xfer) begin
                r_left <= r_left - 2'd1;
            end
            if (xfer) begin
                r_count <= cur_final ? '0 : n_count;
            end
        end
    end

    // Burst characters shift down one place per transfer.
    always_ff @(posedge i_clk) begin
        if (o_burst_take) begin
            r_chars <= i_burst.chars;
        end else if (xfer) begin
            r_chars <= {8'h00, r_chars[2:1]};
        end
    end

    // The terminator transfer restarts the length count.
    a_final_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (xfer && cur_final) |=> (r_count == '0))
        else $error("length count not cleared after terminator");

    // A character transfer counts one more unless saturated.
    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (xfer && !cur_final && !o_burst_take) |=>
            (r_count == $past(r_count) + 1'b1 || r_count == LenMax))
        else $error("length count did not advance");

    // A new burst only replaces a finished one.
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_burst_take && r_left == 2'd1) |-> xfer)
        else $error("burst overwritten before its last result was sent");

endmodule

FILE: rtl/url_percent_decoder.sv
// Top level of the streaming form-urlencoded decoder.
// Instantiates upd_decode and upd_emit; depends on upd_pkg.
//
// Usage:
//   Slave stream: one transfer per input item. tdata[7:0] is the character;
//   tlast marks the end of the string (the character is then ignored).
//   Master stream: one transfer per result. tdata[7:0] is the decoded
//   character (zero on the terminator), tdata[23:8] the saturating decoded
//   length; tuser is the stored flag; tlast marks the terminator result.
//   Configuration: i_cfg_we writes i_cfg_wdata into the output capacity
//   register, to be done only while the block is idle.
// Path: an item passes the input register, then the burst register, before
//   its results are presented on the master stream.
// Throughput: one input item per cycle while each item yields at most one
//   result and tready stays high. An item yielding more results holds the
//   burst register until its last is sent; results leave one per cycle.
// Reset: synchronous, active low; clears held characters, the length count
//   and both stages, and loads a capacity of 64. No clearing pass is needed.
// Stall: when the receiver holds tready low, the current result stays, one
//   further item waits in the input register, and then the slave tready drops.
module url_percent_decoder
    import upd_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [7:0]  i_s_axis_tdata,   // [7:0] in_char
    input  logic        i_s_axis_tlast,   // end_of_text
    input  logic        i_cfg_we,
    input  logic [15:0] i_cfg_wdata,      // out_capacity
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [23:0] o_m_axis_tdata,   // [7:0] out_char, [23:8] total_length
    output logic        o_m_axis_tuser,   // stored
    output logic        o_m_axis_tlast    // is_final
);

    t_burst burst;
    logic   burst_vld;
    logic   burst_take;

    upd_decode u_decode (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_s_tvalid   (i_s_axis_tvalid),
        .o_s_tready   (o_s_axis_tready),
        .i_s_tdata    (i_s_axis_tdata),
        .i_s_tlast    (i_s_axis_tlast),
        .o_burst      (burst),
        .o_burst_vld  (burst_vld),
        .i_burst_take (burst_take)
    );

    upd_emit u_emit (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_burst      (burst),
        .i_burst_vld  (burst_vld),
        .o_burst_take (burst_take),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_wdata  (i_cfg_wdata),
        .o_m_tvalid   (o_m_axis_tvalid),
        .i_m_tready   (i_m_axis_tready),
        .o_m_tdata    (o_m_axis_tdata),
        .o_m_tuser    (o_m_axis_tuser),
        .o_m_tlast    (o_m_axis_tlast)
    );

endmodule
